// ===== sv/mrne_pkg.sv =====
package mrne_pkg;

   localparam int DELTA_W = 8;
   localparam int STEP_W  = 7;

   localparam logic [7:0] KEY_LEFT  = 8'h85;
   localparam logic [7:0] KEY_RIGHT = 8'h95;

   localparam logic [7:0] BTN_LEFT  = 8'h01;
   localparam logic [7:0] BTN_RIGHT = 8'h02;

   localparam logic [STEP_W-1:0] NAV_STEP_RESET = 7'd24;
   localparam logic [6:0]        MIN_REPORT_LEN = 7'd3;

   localparam logic ACT_REPORT = 1'b0;
   localparam logic ACT_STOP   = 1'b1;

   localparam logic EVT_KEY = 1'b0;
   localparam logic EVT_NAV = 1'b1;

   typedef struct packed {
      logic               start;
      logic [DELTA_W-1:0] dividend;
      logic [STEP_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DELTA_W-1:0] quotient;
      logic [STEP_W-1:0]  remainder;
   } div_rsp_type;

endpackage

// ===== sv/mrne_div.sv =====
module mrne_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mrne_pkg::div_req_type div_req,
   output mrne_pkg::div_rsp_type div_rsp
);

   localparam int STEPS = mrne_pkg::DELTA_W;
   localparam int CNT_W = $clog2(STEPS);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [mrne_pkg::DELTA_W-1:0] quo_ff, quo_in;
   logic [mrne_pkg::STEP_W-1:0]  rem_ff, rem_in;

   logic [mrne_pkg::STEP_W:0]    trial;
   logic [mrne_pkg::STEP_W:0]    diff;
   logic                         fits;

   always_comb begin
      trial = {rem_ff, quo_ff[mrne_pkg::DELTA_W-1]};
      diff  = trial - {1'b0, div_req.divisor};
      fits  = trial >= {1'b0, div_req.divisor};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[mrne_pkg::DELTA_W-2:0], fits};
         rem_in = fits ? diff[mrne_pkg::STEP_W-1:0] : trial[mrne_pkg::STEP_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== sv/mouse_report_to_nav_events.sv =====
// Decodes boot-protocol mouse reports into key and navigation events.
// The req channel carries one report or stop item; the rsp channel returns up
// to three events per item in the order left key or click, right key, then
// navigation, with rsp_last set on the final one. Items that cause no event
// return nothing. The csr port writes the step size used in UI mode.
// An item is taken only while req_stall is low, one item at a time.
// A report of length 3 or more in UI mode with nonzero motion runs two
// restoring divisions on one shared subtract-and-compare unit, first vertical
// then horizontal; each loads its operands, then finds one quotient bit per
// iteration. After the divisions, or directly after acceptance for any other
// item, the sequencer loads the item's events one at a time into the output
// register. It returns to idle when the final event is loaded, or when it
// finds no event pending, and only then takes the next item, so a UI item with
// motion holds the input through both divisions and all of its events.
// The rsp side is one output register; while rsp_stall is high it holds its
// item, and the block waits before loading the next event of the same item.
// The final event of an item may still wait there while the next item is
// taken. Synchronous reset clears the held buttons, both residuals, all
// pending events and the output valid flag, and sets the step size to 24.
module mouse_report_to_nav_events (
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_write_enable,
   input  logic [6:0]        csr_write_data,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [6:0]        req_report_length,
   input  logic [7:0]        req_buttons,
   input  logic signed [7:0] req_delta_x,
   input  logic signed [7:0] req_delta_y,
   input  logic              req_raw_mode,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_event_kind,
   output logic [7:0]        rsp_key_code,
   output logic              rsp_key_pressed,
   output logic [7:0]        rsp_nav_up,
   output logic [7:0]        rsp_nav_down,
   output logic [7:0]        rsp_nav_left,
   output logic [7:0]        rsp_nav_right,
   output logic              rsp_nav_click,
   output logic              rsp_last
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV_Y, ST_DIV_X, ST_EMIT} state_type;

   state_type   state_ff, state_in;
   logic [6:0]  nav_step_ff, nav_step_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  res_x_ff, res_x_in;
   logic [7:0]  res_y_ff, res_y_in;
   logic        pend_l_ff, pend_l_in;
   logic        pend_r_ff, pend_r_in;
   logic        pend_n_ff, pend_n_in;
   logic        left_click_ff, left_click_in;
   logic        left_pressed_ff, left_pressed_in;
   logic        right_pressed_ff, right_pressed_in;
   logic [7:0]  nav_up_ff, nav_up_in;
   logic [7:0]  nav_down_ff, nav_down_in;
   logic [7:0]  nav_left_ff, nav_left_in;
   logic [7:0]  nav_right_ff, nav_right_in;
   logic        neg_x_ff, neg_x_in;
   logic        neg_y_ff, neg_y_in;
   logic [7:0]  mag_x_ff, mag_x_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_code_ff, rsp_code_in;
   logic        rsp_pressed_ff, rsp_pressed_in;
   logic [7:0]  rsp_up_ff, rsp_up_in;
   logic [7:0]  rsp_down_ff, rsp_down_in;
   logic [7:0]  rsp_left_ff, rsp_left_in;
   logic [7:0]  rsp_right_ff, rsp_right_in;
   logic        rsp_click_ff, rsp_click_in;
   logic        rsp_last_ff, rsp_last_in;

   mrne_pkg::div_req_type div_req;
   mrne_pkg::div_rsp_type div_rsp;

   logic        accept;
   logic        is_stop;
   logic        report_ok;
   logic        motion;
   logic        ui_motion;
   logic [7:0]  changed;
   logic [7:0]  dx_u;
   logic [7:0]  dy_u;
   logic [8:0]  sum_x;
   logic [8:0]  sum_y;
   logic [8:0]  neg_sum_x;
   logic [8:0]  neg_sum_y;
   logic [7:0]  mag_y;
   logic [6:0]  step_eff;
   logic [7:0]  rem_pos;
   logic [7:0]  rem_neg;
   logic        out_free;
   logic        load;
   logic [7:0]  res_x_abs;

   mrne_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      step_eff  = (nav_step_ff == 7'd0) ? 7'd1 : nav_step_ff;
      accept    = req_valid && (state_ff == ST_IDLE);
      is_stop   = req_action == mrne_pkg::ACT_STOP;
      report_ok = !is_stop && (req_report_length >= mrne_pkg::MIN_REPORT_LEN);
      changed   = req_buttons ^ held_ff;
      dx_u      = req_delta_x;
      dy_u      = req_delta_y;
      motion    = (dx_u != 8'd0) || (dy_u != 8'd0);
      ui_motion = report_ok && !req_raw_mode && motion;

      sum_x     = {res_x_ff[7], res_x_ff} + {dx_u[7], dx_u};
      sum_y     = {res_y_ff[7], res_y_ff} + {dy_u[7], dy_u};
      neg_sum_x = 9'd0 - sum_x;
      neg_sum_y = 9'd0 - sum_y;
      mag_y     = sum_y[8] ? neg_sum_y[7:0] : sum_y[7:0];

      rem_pos   = {1'b0, div_rsp.remainder};
      rem_neg   = 8'd0 - rem_pos;
      res_x_abs = res_x_ff[7] ? (8'd0 - res_x_ff) : res_x_ff;

      div_req.start    = (accept && ui_motion) || ((state_ff == ST_DIV_Y) && div_rsp.done);
      div_req.dividend = (state_ff == ST_IDLE) ? mag_y : mag_x_ff;
      div_req.divisor  = step_eff;

      out_free = !rsp_valid_ff || !rsp_stall;
      load     = (state_ff == ST_EMIT) && out_free && (pend_l_ff || pend_r_ff || pend_n_ff);

      state_in         = state_ff;
      nav_step_in      = csr_write_enable ? csr_write_data : nav_step_ff;
      held_in          = held_ff;
      res_x_in         = res_x_ff;
      res_y_in         = res_y_ff;
      pend_l_in        = pend_l_ff;
      pend_r_in        = pend_r_ff;
      pend_n_in        = pend_n_ff;
      left_click_in    = left_click_ff;
      left_pressed_in  = left_pressed_ff;
      right_pressed_in = right_pressed_ff;
      nav_up_in        = nav_up_ff;
      nav_down_in      = nav_down_ff;
      nav_left_in      = nav_left_ff;
      nav_right_in     = nav_right_ff;
      neg_x_in         = neg_x_ff;
      neg_y_in         = neg_y_ff;
      mag_x_in         = mag_x_ff;

      rsp_valid_in   = load || (rsp_valid_ff && rsp_stall);
      rsp_kind_in    = rsp_kind_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_up_in      = rsp_up_ff;
      rsp_down_in    = rsp_down_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_right_in   = rsp_right_ff;
      rsp_click_in   = rsp_click_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ui_motion ? ST_DIV_Y : ST_EMIT;
               pend_l_in = 1'b0;
               pend_r_in = 1'b0;
               pend_n_in = 1'b0;
               if (is_stop) begin
                  pend_l_in        = req_raw_mode && ((held_ff & mrne_pkg::BTN_LEFT) != 8'd0);
                  pend_r_in        = req_raw_mode && ((held_ff & mrne_pkg::BTN_RIGHT) != 8'd0);
                  left_click_in    = 1'b0;
                  left_pressed_in  = 1'b0;
                  right_pressed_in = 1'b0;
                  held_in          = 8'd0;
               end else if (report_ok) begin
                  pend_l_in = ((changed & mrne_pkg::BTN_LEFT) != 8'd0) &&
                              (req_raw_mode || ((req_buttons & mrne_pkg::BTN_LEFT) != 8'd0));
                  pend_r_in = ((changed & mrne_pkg::BTN_RIGHT) != 8'd0) && req_raw_mode;
                  left_click_in    = !req_raw_mode;
                  left_pressed_in  = (req_buttons & mrne_pkg::BTN_LEFT) != 8'd0;
                  right_pressed_in = (req_buttons & mrne_pkg::BTN_RIGHT) != 8'd0;
                  held_in          = req_buttons;
                  if (motion && req_raw_mode) begin
                     pend_n_in    = 1'b1;
                     nav_up_in    = dy_u[7] ? (8'd0 - dy_u) : 8'd0;
                     nav_down_in  = dy_u[7] ? 8'd0 : dy_u;
                     nav_left_in  = dx_u[7] ? (8'd0 - dx_u) : 8'd0;
                     nav_right_in = dx_u[7] ? 8'd0 : dx_u;
                     res_x_in     = 8'd0;
                     res_y_in     = 8'd0;
                  end
                  neg_x_in = sum_x[8];
                  neg_y_in = sum_y[8];
                  mag_x_in = sum_x[8] ? neg_sum_x[7:0] : sum_x[7:0];
               end
            end
         end
         ST_DIV_Y: begin
            if (div_rsp.done) begin
               nav_up_in   = neg_y_ff ? div_rsp.quotient : 8'd0;
               nav_down_in = neg_y_ff ? 8'd0 : div_rsp.quotient;
               res_y_in    = neg_y_ff ? rem_neg : rem_pos;
               state_in    = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_rsp.done) begin
               nav_left_in  = neg_x_ff ? div_rsp.quotient : 8'd0;
               nav_right_in = neg_x_ff ? 8'd0 : div_rsp.quotient;
               res_x_in     = neg_x_ff ? rem_neg : rem_pos;
               pend_n_in    = (nav_up_ff != 8'd0) || (nav_down_ff != 8'd0) ||
                              (div_rsp.quotient != 8'd0);
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!(pend_l_ff || pend_r_ff || pend_n_ff)) begin
               state_in = ST_IDLE;
            end else if (load) begin
               rsp_code_in    = 8'd0;
               rsp_pressed_in = 1'b0;
               rsp_up_in      = 8'd0;
               rsp_down_in    = 8'd0;
               rsp_left_in    = 8'd0;
               rsp_right_in   = 8'd0;
               rsp_click_in   = 1'b0;
               if (pend_l_ff) begin
                  pend_l_in   = 1'b0;
                  rsp_last_in = !(pend_r_ff || pend_n_ff);
                  if (left_click_ff) begin
                     rsp_kind_in  = mrne_pkg::EVT_NAV;
                     rsp_click_in = 1'b1;
                  end else begin
                     rsp_kind_in    = mrne_pkg::EVT_KEY;
                     rsp_code_in    = mrne_pkg::KEY_LEFT;
                     rsp_pressed_in = left_pressed_ff;
                  end
               end else if (pend_r_ff) begin
                  pend_r_in      = 1'b0;
                  rsp_last_in    = !pend_n_ff;
                  rsp_kind_in    = mrne_pkg::EVT_KEY;
                  rsp_code_in    = mrne_pkg::KEY_RIGHT;
                  rsp_pressed_in = right_pressed_ff;
               end else begin
                  pend_n_in    = 1'b0;
                  rsp_last_in  = 1'b1;
                  rsp_kind_in  = mrne_pkg::EVT_NAV;
                  rsp_up_in    = nav_up_ff;
                  rsp_down_in  = nav_down_ff;
                  rsp_left_in  = nav_left_ff;
                  rsp_right_in = nav_right_ff;
               end
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nav_step_ff  <= mrne_pkg::NAV_STEP_RESET;
         held_ff      <= 8'd0;
         res_x_ff     <= 8'd0;
         res_y_ff     <= 8'd0;
         pend_l_ff    <= 1'b0;
         pend_r_ff    <= 1'b0;
         pend_n_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nav_step_ff  <= nav_step_in;
         held_ff      <= held_in;
         res_x_ff     <= res_x_in;
         res_y_ff     <= res_y_in;
         pend_l_ff    <= pend_l_in;
         pend_r_ff    <= pend_r_in;
         pend_n_ff    <= pend_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      left_click_ff    <= left_click_in;
      left_pressed_ff  <= left_pressed_in;
      right_pressed_ff <= right_pressed_in;
      nav_up_ff        <= nav_up_in;
      nav_down_ff      <= nav_down_in;
      nav_left_ff      <= nav_left_in;
      nav_right_ff     <= nav_right_in;
      neg_x_ff         <= neg_x_in;
      neg_y_ff         <= neg_y_in;
      mag_x_ff         <= mag_x_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_code_ff      <= rsp_code_in;
      rsp_pressed_ff   <= rsp_pressed_in;
      rsp_up_ff        <= rsp_up_in;
      rsp_down_ff      <= rsp_down_in;
      rsp_left_ff      <= rsp_left_in;
      rsp_right_ff     <= rsp_right_in;
      rsp_click_ff     <= rsp_click_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign req_stall       = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_key_code    = rsp_code_ff;
   assign rsp_key_pressed = rsp_pressed_ff;
   assign rsp_nav_up      = rsp_up_ff;
   assign rsp_nav_down    = rsp_down_ff;
   assign rsp_nav_left    = rsp_left_ff;
   assign rsp_nav_right   = rsp_right_ff;
   assign rsp_nav_click   = rsp_click_ff;
   assign rsp_last        = rsp_last_ff;

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> ((state_ff == ST_DIV_Y) || (state_ff == ST_DIV_X)))
      else $error("divider finished outside a division state");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(pend_l_ff || pend_r_ff || pend_n_ff))
      else $error("events still pending while idle");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_last_in) |=> (state_ff == ST_IDLE))
      else $error("final event loaded but sequencer did not return to idle");

   a_residual_below_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV_X) && div_rsp.done) |=> (res_x_abs < {1'b0, step_eff}))
      else $error("horizontal residual not below the step size");

endmodule

// ===== tb/mouse_report_to_nav_events_tb.sv =====
module mouse_report_to_nav_events_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HIGH    = 5;
   localparam int CLOCK_LOW     = 5;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 76;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct {
      logic              action;
      logic [6:0]        len;
      logic [7:0]        buttons;
      logic signed [7:0] dx;
      logic signed [7:0] dy;
      logic              raw;
   } report_item_type;

   typedef struct {
      logic       kind;
      logic [7:0] key_code;
      logic       key_pressed;
      logic [7:0] up;
      logic [7:0] down;
      logic [7:0] left;
      logic [7:0] right;
      logic       click;
      logic       last;
   } nav_event_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [6:0]        csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = 1'b0;
   logic [6:0]        req_report_length = '0;
   logic [7:0]        req_buttons = '0;
   logic signed [7:0] req_delta_x = '0;
   logic signed [7:0] req_delta_y = '0;
   logic              req_raw_mode = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_event_kind;
   logic [7:0]        rsp_key_code;
   logic              rsp_key_pressed;
   logic [7:0]        rsp_nav_up;
   logic [7:0]        rsp_nav_down;
   logic [7:0]        rsp_nav_left;
   logic [7:0]        rsp_nav_right;
   logic              rsp_nav_click;
   logic              rsp_last;

   report_item_type pending_reports[$];
   nav_event_type   expected_events[$];
   report_item_type offered;

   logic [6:0] step_setting = mrne_pkg::NAV_STEP_RESET;
   logic [7:0] held_btn = '0;
   int         resid_x = 0;
   int         resid_y = 0;

   int  idle_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_go = 1'b0;
   bit  hold_done = 1'b0;
   bit  sender_steady = 1'b0;
   int  errors = 0;
   int  cycle_count = 0;

   mouse_report_to_nav_events u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_report_length (req_report_length),
      .req_buttons       (req_buttons),
      .req_delta_x       (req_delta_x),
      .req_delta_y       (req_delta_y),
      .req_raw_mode      (req_raw_mode),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_key_code      (rsp_key_code),
      .rsp_key_pressed   (rsp_key_pressed),
      .rsp_nav_up        (rsp_nav_up),
      .rsp_nav_down      (rsp_nav_down),
      .rsp_nav_left      (rsp_nav_left),
      .rsp_nav_right     (rsp_nav_right),
      .rsp_nav_click     (rsp_nav_click),
      .rsp_last          (rsp_last)
   );

   always begin
      #CLOCK_HIGH clock = 1'b1;
      #CLOCK_LOW clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   function automatic nav_event_type key_event(logic [7:0] code, logic pressed);
      nav_event_type ev;
      ev = '{default: '0};
      ev.kind = mrne_pkg::EVT_KEY;
      ev.key_code = code;
      ev.key_pressed = pressed;
      return ev;
   endfunction

   function automatic nav_event_type nav_event(logic [7:0] up, logic [7:0] down,
                                               logic [7:0] left, logic [7:0] right,
                                               logic click);
      nav_event_type ev;
      ev = '{default: '0};
      ev.kind = mrne_pkg::EVT_NAV;
      ev.up = up;
      ev.down = down;
      ev.left = left;
      ev.right = right;
      ev.click = click;
      return ev;
   endfunction

   task automatic split_axis(inout int acc, input int step,
                             output logic [7:0] neg, output logic [7:0] pos);
      int m;
      neg = '0;
      pos = '0;
      if (acc < 0) begin
         m = -acc;
         neg = 8'(m / step);
         acc = -(m % step);
      end else begin
         m = acc;
         pos = 8'(m / step);
         acc = m % step;
      end
   endtask

   task automatic decode_report(input report_item_type it);
      nav_event_type evs[$];
      logic [7:0]    changed;
      logic [7:0]    up, down, left, right;
      int            step;
      int            dx, dy;
      step = (step_setting == 0) ? 1 : int'(step_setting);
      dx = it.dx;
      dy = it.dy;
      if (it.action == mrne_pkg::ACT_STOP) begin
         if (it.raw) begin
            if ((held_btn & mrne_pkg::BTN_LEFT) != 0)
               evs.push_back(key_event(mrne_pkg::KEY_LEFT, 1'b0));
            if ((held_btn & mrne_pkg::BTN_RIGHT) != 0)
               evs.push_back(key_event(mrne_pkg::KEY_RIGHT, 1'b0));
         end
         held_btn = '0;
      end else if (it.len >= mrne_pkg::MIN_REPORT_LEN) begin
         changed = it.buttons ^ held_btn;
         if ((changed & mrne_pkg::BTN_LEFT) != 0) begin
            if (it.raw)
               evs.push_back(key_event(mrne_pkg::KEY_LEFT,
                                       (it.buttons & mrne_pkg::BTN_LEFT) != 0));
            else if ((it.buttons & mrne_pkg::BTN_LEFT) != 0)
               evs.push_back(nav_event(8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
         end
         if ((changed & mrne_pkg::BTN_RIGHT) != 0 && it.raw)
            evs.push_back(key_event(mrne_pkg::KEY_RIGHT,
                                    (it.buttons & mrne_pkg::BTN_RIGHT) != 0));
         held_btn = it.buttons;
         if (dx != 0 || dy != 0) begin
            if (it.raw) begin
               evs.push_back(nav_event(8'(dy < 0 ? -dy : 0), 8'(dy > 0 ? dy : 0),
                                       8'(dx < 0 ? -dx : 0), 8'(dx > 0 ? dx : 0), 1'b0));
               resid_x = 0;
               resid_y = 0;
            end else begin
               resid_x += dx;
               resid_y += dy;
               split_axis(resid_y, step, up, down);
               split_axis(resid_x, step, left, right);
               if ((up | down | left | right) != 8'd0)
                  evs.push_back(nav_event(up, down, left, right, 1'b0));
            end
         end
      end
      if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
      foreach (evs[i]) expected_events.push_back(evs[i]);
   endtask

   function automatic report_item_type mk_report(logic action, int len,
                                                 logic [7:0] buttons, int dx, int dy,
                                                 logic raw);
      report_item_type it;
      it.action = action;
      it.len = 7'(len);
      it.buttons = buttons;
      it.dx = 8'(dx);
      it.dy = 8'(dy);
      it.raw = raw;
      return it;
   endfunction

   function automatic int random_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return 0;
      if (r < 65) return int'($urandom_range(0, 12)) - 6;
      return int'($urandom_range(0, 255)) - 128;
   endfunction

   function automatic report_item_type random_report();
      report_item_type it;
      int r;
      it.action = ($urandom_range(0, 99) < 8) ? mrne_pkg::ACT_STOP : mrne_pkg::ACT_REPORT;
      r = $urandom_range(0, 99);
      if (r < 8) it.len = 7'($urandom_range(0, 2));
      else if (r < 85) it.len = 7'($urandom_range(3, 8));
      else it.len = 7'($urandom_range(9, 127));
      if ($urandom_range(0, 99) < 75) it.buttons = 8'($urandom_range(0, 3));
      else it.buttons = 8'($urandom_range(0, 255));
      it.dx = 8'(random_delta());
      it.dy = 8'(random_delta());
      it.raw = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reports.size() != 0 || req_valid || expected_events.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_step(input logic [6:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      step_setting = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic add_random(input int count);
      for (int i = 0; i < count; i++) pending_reports.push_back(random_report());
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : req_drive
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_valid && !req_stall) decode_report(offered);
         if (!req_valid || !req_stall) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (pending_reports.size() > 0) begin
               offered = pending_reports.pop_front();
               req_action <= offered.action;
               req_report_length <= offered.len;
               req_buttons <= offered.buttons;
               req_delta_x <= offered.dx;
               req_delta_y <= offered.dy;
               req_raw_mode <= offered.raw;
               req_valid <= 1'b1;
               idle_left = sender_steady ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_hold
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = sender_steady ? 0 : pick_gap();
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      nav_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: item with no expected event, kind %0h key %0h", $time,
                     rsp_event_kind, rsp_key_code);
         end else begin
            want = expected_events.pop_front();
            check_field("event_kind", 8'(want.kind), 8'(rsp_event_kind));
            check_field("key_code", want.key_code, rsp_key_code);
            check_field("key_pressed", 8'(want.key_pressed), 8'(rsp_key_pressed));
            check_field("nav_up", want.up, rsp_nav_up);
            check_field("nav_down", want.down, rsp_nav_down);
            check_field("nav_left", want.left, rsp_nav_left);
            check_field("nav_right", want.right, rsp_nav_right);
            check_field("nav_click", 8'(want.click), 8'(rsp_nav_click));
            check_field("last", 8'(want.last), 8'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d events still expected", $time,
                  expected_events.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Raw mode button edges and motion extremes.
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h01, 0, 0, 1'b1));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h03, 127, -128, 1'b1));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h00, -128, 127, 1'b1));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 4, 8'hFC, 0, 0, 1'b1));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 2, 8'h03, 5, 5, 1'b1));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 0, 8'h00, -1, -1, 1'b1));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 64, 8'h03, 0, -1, 1'b1));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_STOP, 0, 8'hFF, 9, 9, 1'b1));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_STOP, 5, 8'h00, 0, 0, 1'b1));
      // UI mode clicks, ignored right button and step quantization.
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h01, 0, 0, 1'b0));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h03, 0, 0, 1'b0));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h02, 10, 0, 1'b0));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h02, 20, -30, 1'b0));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h02, -128, 127, 1'b0));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h01, 0, 0, 1'b0));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_STOP, 3, 8'h01, 0, 0, 1'b0));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h01, 1, 0, 1'b0));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 127, 8'hFF, 1, -1, 1'b1));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h7E, 24, -24, 1'b0));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h80, -23, 23, 1'b0));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_STOP, 1, 8'h00, 0, 0, 1'b1));
      pending_reports.push_back(mk_report(mrne_pkg::ACT_REPORT, 3, 8'h00, 0, 0, 1'b0));
      wait_drained();

      write_step(7'd0);
      add_random(PHASE_ITEMS);
      wait_drained();

      write_step(7'd127);
      add_random(PHASE_ITEMS);
      wait_drained();

      // The receiver holds off while items keep coming, so the block backs up.
      write_step(7'd1);
      @(negedge clock);
      hold_go = 1'b1;
      add_random(PHASE_ITEMS);
      wait_drained();

      write_step(7'($urandom_range(2, 126)));
      add_random(PHASE_ITEMS);
      wait_drained();

      write_step(mrne_pkg::NAV_STEP_RESET);
      @(negedge clock);
      sender_steady = 1'b1;
      add_random(PHASE_ITEMS);
      wait_drained();

      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
